// File: hdl/steer_map_inverse_lookup_assert.svh
// ----------------------------------------------------------------------------
// steer_map_inverse_lookup_assert
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef STEER_MAP_INVERSE_LOOKUP_ASSERT_SVH
`define STEER_MAP_INVERSE_LOOKUP_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define SMIL_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SMIL_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/smil_pkg.sv
// ----------------------------------------------------------------------------
// smil_pkg
// Shared types and constants of the steering map inverse lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package smil_pkg;

  parameter int VAL_W     = 32;
  parameter int CMD_W     = 2;
  parameter int SEL_W     = 4;
  parameter int CFG_W     = 5;
  parameter int CFG_IDX_W = 4;
  parameter int CFG_DAT_W = 32;

  parameter int MAX_STEER_POINTS_DEF  = 16;
  parameter int MAX_OUTPUT_POINTS_DEF = 16;

  // Reset value of both point count registers.
  parameter logic [CFG_W-1:0] POINTS_RESET = 5'd16;

  // Configuration register indexes.
  parameter logic [CFG_IDX_W-1:0] REG_STEER_POINTS  = 4'd0;
  parameter logic [CFG_IDX_W-1:0] REG_OUTPUT_POINTS = 4'd1;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_STEER  = 2'd0,
    CMD_WR_OUTPUT = 2'd1,
    CMD_WR_CELL   = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  // Request into the shared interpolation unit.
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] k0;
    logic [VAL_W-1:0] k1;
    logic [VAL_W-1:0] q;
    logic [VAL_W-1:0] v0;
    logic [VAL_W-1:0] v1;
  } interp_req_t;

  // Response of the shared interpolation unit.
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } interp_rsp_t;

endpackage

`default_nettype wire

// File: hdl/smil_if.sv
// ----------------------------------------------------------------------------
// smil_if
// Valid/ready channels of the steering map inverse lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

// Input items: table writes and queries.
interface smil_item_if;
  import smil_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [SEL_W-1:0]        row_sel;
  logic [SEL_W-1:0]        col_sel;
  logic signed [VAL_W-1:0] entry_value;
  logic signed [VAL_W-1:0] steer_angle;
  logic signed [VAL_W-1:0] steer_rate_req;
  modport source (output valid, cmd, row_sel, col_sel, entry_value, steer_angle,
                  steer_rate_req, input ready);
  modport sink (input valid, cmd, row_sel, col_sel, entry_value, steer_angle,
                steer_rate_req, output ready);
endinterface

// Result items: one output command per query.
interface smil_result_if;
  import smil_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] command_out;
  modport source (output valid, command_out, input ready);
  modport sink (input valid, command_out, output ready);
endinterface

// Configuration register writes.
interface smil_cfg_if;
  import smil_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/smil_interp.sv
// ----------------------------------------------------------------------------
// smil_interp
// Shared linear interpolation unit: one 32x32 multiply, then a restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smil_interp (
  input  logic                  clk,
  input  logic                  rst,
  input  smil_pkg::interp_req_t req,
  output smil_pkg::interp_rsp_t rsp
);
  import smil_pkg::*;

  localparam int PROD_W    = 2 * VAL_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_DONE = 4'b1000
  } ustate_t;

  ustate_t                  state;
  logic [VAL_W-1:0]         v0;
  logic                     neg;
  logic [VAL_W-1:0]         den;
  logic [VAL_W-1:0]         num;
  logic [VAL_W-1:0]         mag;
  logic [VAL_W-1:0]         rem;
  logic [PROD_W-1:0]        quo;
  logic [CNT_W-1:0]         cnt;

  logic signed [VAL_W:0]    dk, dq, dv;
  logic signed [VAL_W:0]    ndk, ndq, ndv;
  logic [VAL_W-1:0]         den_c, num_raw, num_c, mag_c;
  logic [VAL_W:0]           shifted;
  logic                     take;

  // Segment width, query offset and value step, widened by one bit.
  always_comb begin
    dk  = $signed({req.k1[VAL_W-1], req.k1}) - $signed({req.k0[VAL_W-1], req.k0});
    dq  = $signed({req.q[VAL_W-1], req.q}) - $signed({req.k0[VAL_W-1], req.k0});
    dv  = $signed({req.v1[VAL_W-1], req.v1}) - $signed({req.v0[VAL_W-1], req.v0});
    ndk = -dk;
    ndq = -dq;
    ndv = -dv;
    if (dk > 0) begin
      den_c   = dk[VAL_W-1:0];
      num_raw = dq[VAL_W] ? '0 : dq[VAL_W-1:0];
    end else begin
      den_c   = ndk[VAL_W-1:0];
      num_raw = (dq > 0) ? '0 : ndq[VAL_W-1:0];
    end
    num_c = (num_raw > den_c) ? den_c : num_raw;
    mag_c = dv[VAL_W] ? ndv[VAL_W-1:0] : dv[VAL_W-1:0];
  end

  // One restoring division step.
  always_comb begin
    shifted = {rem, quo[PROD_W-1]};
    take    = shifted >= {1'b0, den};
  end

  // Sequencer of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      case (state)
        U_IDLE: begin
          if (req.start) begin
            v0  <= req.v0;
            neg <= dv[VAL_W];
            den <= den_c;
            num <= num_c;
            mag <= mag_c;
            if (req.k1 == req.k0) begin
              quo   <= '0;
              state <= U_DONE;
            end else begin
              state <= U_MUL;
            end
          end
        end
        U_MUL: begin
          quo   <= PROD_W'(mag) * PROD_W'(num);
          rem   <= '0;
          cnt   <= '0;
          state <= U_DIV;
        end
        U_DIV: begin
          rem <= take ? VAL_W'(shifted - {1'b0, den}) : shifted[VAL_W-1:0];
          quo <= {quo[PROD_W-2:0], take};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= U_DONE;
          end
        end
        U_DONE: begin
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  // The quotient never exceeds the value step, so its low half is exact.
  assign rsp.done  = (state == U_DONE);
  assign rsp.value = neg ? (v0 - quo[VAL_W-1:0]) : (v0 + quo[VAL_W-1:0]);

endmodule

`default_nettype wire

// File: hdl/smil_seq.sv
// ----------------------------------------------------------------------------
// smil_seq
// Table memories and query sequencer; drives the shared interpolation unit
// once per map row and once for the inverse lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module smil_seq #(
  parameter int MAX_STEER_POINTS  = smil_pkg::MAX_STEER_POINTS_DEF,
  parameter int MAX_OUTPUT_POINTS = smil_pkg::MAX_OUTPUT_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  smil_item_if.sink                  item,
  smil_result_if.source              result,
  input  logic [smil_pkg::CFG_W-1:0] steer_points_used,
  input  logic [smil_pkg::CFG_W-1:0] output_points_used,
  output smil_pkg::interp_req_t      ureq,
  input  smil_pkg::interp_rsp_t      ursp
);
  import smil_pkg::*;

  localparam int SW = $clog2(MAX_STEER_POINTS);
  localparam int OW = $clog2(MAX_OUTPUT_POINTS);
  localparam int MD = MAX_STEER_POINTS * MAX_OUTPUT_POINTS;
  localparam int MW = $clog2(MD);

  typedef enum logic [23:0] {
    IDLE    = 24'h000001,
    S_MM_A  = 24'h000002,
    S_MM_U  = 24'h000004,
    S_CLAMP = 24'h000008,
    S_SEG_A = 24'h000010,
    S_SEG_U = 24'h000020,
    S_K0_A  = 24'h000040,
    S_K0_U  = 24'h000080,
    R_A0    = 24'h000100,
    R_U0    = 24'h000200,
    R_A1    = 24'h000400,
    R_U1    = 24'h000800,
    R_WAIT  = 24'h001000,
    C_CLAMP = 24'h002000,
    C_SEG_A = 24'h004000,
    C_SEG_U = 24'h008000,
    C_K0_A  = 24'h010000,
    C_K0_U  = 24'h020000,
    O_A0    = 24'h040000,
    O_U0    = 24'h080000,
    O_A1    = 24'h100000,
    O_U1    = 24'h200000,
    O_WAIT  = 24'h400000,
    DONE    = 24'h800000
  } state_t;

  state_t state;

  // Table storage.
  logic signed [VAL_W-1:0] steer_axis  [MAX_STEER_POINTS];
  logic signed [VAL_W-1:0] output_axis [MAX_OUTPUT_POINTS];
  logic signed [VAL_W-1:0] rate_map    [MD];
  logic signed [VAL_W-1:0] rate_column [MAX_OUTPUT_POINTS];

  logic signed [VAL_W-1:0] sa_rd, oa_rd, map_rd, rc_rd;
  logic [SW-1:0]           sa_addr;
  logic [OW-1:0]           oa_addr, rc_addr;
  logic [MW-1:0]           map_addr, map_waddr;

  // Working registers.
  logic [SW-1:0]           j, seg_s;
  logic [OW-1:0]           r, seg_o;
  logic signed [VAL_W-1:0] angle, rate_req, qv, lo, hi, k0, k1, v0, res;
  logic                    out_valid;
  logic [VAL_W-1:0]        out_data;

  logic [SW:0]             ns;
  logic [OW:0]             no;
  logic [SW-1:0]           ns_m1, ns_m2;
  logic [OW-1:0]           no_m1, no_m2;
  logic                    acc, out_free;

  // Point counts, limited to the range the tables support.
  always_comb begin
    if (steer_points_used < CFG_W'(2)) begin
      ns = (SW+1)'(2);
    end else if (int'(steer_points_used) > MAX_STEER_POINTS) begin
      ns = (SW+1)'(MAX_STEER_POINTS);
    end else begin
      ns = (SW+1)'(steer_points_used);
    end
    if (output_points_used < CFG_W'(2)) begin
      no = (OW+1)'(2);
    end else if (int'(output_points_used) > MAX_OUTPUT_POINTS) begin
      no = (OW+1)'(MAX_OUTPUT_POINTS);
    end else begin
      no = (OW+1)'(output_points_used);
    end
    ns_m1 = SW'(ns - (SW+1)'(1));
    ns_m2 = SW'(ns - (SW+1)'(2));
    no_m1 = OW'(no - (OW+1)'(1));
    no_m2 = OW'(no - (OW+1)'(2));
  end

  assign item.ready = (state == IDLE);
  assign acc        = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;

  // Read addresses follow the state that issues each read.
  always_comb begin
    if (state == S_SEG_A) begin
      sa_addr = seg_s + SW'(1);
    end else if (state == S_K0_A) begin
      sa_addr = seg_s;
    end else begin
      sa_addr = j;
    end
    map_addr  = MW'(r) * MW'(MAX_STEER_POINTS) + MW'(seg_s) + MW'(state == R_A1);
    rc_addr   = (state == C_SEG_A) ? seg_o + OW'(1) : seg_o;
    oa_addr   = (state == O_A1) ? seg_o + OW'(1) : seg_o;
    map_waddr = MW'(item.row_sel) * MW'(MAX_STEER_POINTS) + MW'(item.col_sel);
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (acc && item.cmd == CMD_WR_STEER && int'(item.col_sel) < MAX_STEER_POINTS) begin
      steer_axis[SW'(item.col_sel)] <= item.entry_value;
    end
    if (acc && item.cmd == CMD_WR_OUTPUT && int'(item.row_sel) < MAX_OUTPUT_POINTS) begin
      output_axis[OW'(item.row_sel)] <= item.entry_value;
    end
    if (acc && item.cmd == CMD_WR_CELL && int'(item.row_sel) < MAX_OUTPUT_POINTS
        && int'(item.col_sel) < MAX_STEER_POINTS) begin
      rate_map[map_waddr] <= item.entry_value;
    end
    if (state == R_WAIT && ursp.done) begin
      rate_column[r] <= ursp.value;
    end
    sa_rd  <= steer_axis[sa_addr];
    oa_rd  <= output_axis[oa_addr];
    map_rd <= rate_map[map_addr];
    rc_rd  <= rate_column[rc_addr];
  end

  // Request to the interpolation unit; the upper value comes straight
  // from the memory read of the same cycle.
  always_comb begin
    ureq.start = (state == R_U1) || (state == O_U1);
    ureq.k0    = k0;
    ureq.k1    = k1;
    ureq.q     = qv;
    ureq.v0    = v0;
    ureq.v1    = (state == O_U1) ? oa_rd : map_rd;
  end

  // Query sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (acc && item.cmd == CMD_QUERY) begin
            angle    <= item.steer_angle;
            rate_req <= item.steer_rate_req;
            j        <= '0;
            state    <= S_MM_A;
          end
        end
        S_MM_A: state <= S_MM_U;
        S_MM_U: begin
          if (j == '0) begin
            lo <= sa_rd;
            hi <= sa_rd;
          end else begin
            if (sa_rd < lo) lo <= sa_rd;
            if (sa_rd > hi) hi <= sa_rd;
          end
          if (j == ns_m1) begin
            state <= S_CLAMP;
          end else begin
            j     <= j + SW'(1);
            state <= S_MM_A;
          end
        end
        S_CLAMP: begin
          qv    <= (angle < lo) ? lo : ((angle > hi) ? hi : angle);
          seg_s <= '0;
          state <= S_SEG_A;
        end
        S_SEG_A: state <= S_SEG_U;
        S_SEG_U: begin
          if (seg_s == ns_m2 || sa_rd >= qv) begin
            k1    <= sa_rd;
            state <= S_K0_A;
          end else begin
            seg_s <= seg_s + SW'(1);
            state <= S_SEG_A;
          end
        end
        S_K0_A: state <= S_K0_U;
        S_K0_U: begin
          k0    <= sa_rd;
          r     <= '0;
          state <= R_A0;
        end
        R_A0: state <= R_U0;
        R_U0: begin
          v0    <= map_rd;
          state <= R_A1;
        end
        R_A1: state <= R_U1;
        R_U1: state <= R_WAIT;
        R_WAIT: begin
          if (ursp.done) begin
            // Running range of the row rates.
            if (r == '0) begin
              lo <= ursp.value;
              hi <= ursp.value;
            end else begin
              if ($signed(ursp.value) < lo) lo <= ursp.value;
              if ($signed(ursp.value) > hi) hi <= ursp.value;
            end
            if (r == no_m1) begin
              state <= C_CLAMP;
            end else begin
              r     <= r + OW'(1);
              state <= R_A0;
            end
          end
        end
        C_CLAMP: begin
          qv    <= (rate_req < lo) ? lo : ((rate_req > hi) ? hi : rate_req);
          seg_o <= '0;
          state <= C_SEG_A;
        end
        C_SEG_A: state <= C_SEG_U;
        C_SEG_U: begin
          if (seg_o == no_m2 || rc_rd >= qv) begin
            k1    <= rc_rd;
            state <= C_K0_A;
          end else begin
            seg_o <= seg_o + OW'(1);
            state <= C_SEG_A;
          end
        end
        C_K0_A: state <= C_K0_U;
        C_K0_U: begin
          k0    <= rc_rd;
          state <= O_A0;
        end
        O_A0: state <= O_U0;
        O_U0: begin
          v0    <= oa_rd;
          state <= O_A1;
        end
        O_A1: state <= O_U1;
        O_U1: state <= O_WAIT;
        O_WAIT: begin
          if (ursp.done) begin
            res   <= ursp.value;
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Output register; holds a result until its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DONE && out_free) begin
      out_data <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.command_out = out_data;

endmodule

`default_nettype wire

// File: hdl/steer_map_inverse_lookup.sv
// ----------------------------------------------------------------------------
// steer_map_inverse_lookup
// Steering calibration map with clamped linear lookup along each map row and inverse
// interpolation to an output command.
// ----------------------------------------------------------------------------
// A write beat (steer axis, output axis or map cell) leaves the block ready
// again at once. After a query beat the block stays busy while every map row
// and the final inverse step each pass through one shared interpolation
// unit, whose bit-serial divider sets most of the busy time. A segment found
// early or of zero width (which skips the divider) shortens it. The block
// accepts no beat while a query runs; a finished result waits in an output
// register, so the next write can be accepted before it is taken.
// Table entries must be written before a query reads them.
`default_nettype none

module steer_map_inverse_lookup #(
  parameter int MAX_STEER_POINTS  = smil_pkg::MAX_STEER_POINTS_DEF,
  parameter int MAX_OUTPUT_POINTS = smil_pkg::MAX_OUTPUT_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  smil_item_if.sink     item,
  smil_result_if.source result,
  smil_cfg_if.sink      cfg
);
  import smil_pkg::*;

  logic [CFG_W-1:0] steer_points_used;
  logic [CFG_W-1:0] output_points_used;
  interp_req_t      ureq;
  interp_rsp_t      ursp;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_points_used  <= POINTS_RESET;
      output_points_used <= POINTS_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_STEER_POINTS) begin
        steer_points_used <= cfg.data[CFG_W-1:0];
      end
      if (cfg.index == REG_OUTPUT_POINTS) begin
        output_points_used <= cfg.data[CFG_W-1:0];
      end
    end
  end

  // Tables and query sequencer.
  smil_seq #(
    .MAX_STEER_POINTS  (MAX_STEER_POINTS),
    .MAX_OUTPUT_POINTS (MAX_OUTPUT_POINTS)
  ) u_seq (
    .clk                (clk),
    .rst                (rst),
    .item               (item),
    .result             (result),
    .steer_points_used  (steer_points_used),
    .output_points_used (output_points_used),
    .ureq               (ureq),
    .ursp               (ursp)
  );

  // Shared interpolation unit.
  smil_interp u_interp (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

endmodule

`default_nettype wire

// File: hdl/smil_chk.sv
// ----------------------------------------------------------------------------
// smil_chk
// Port-level checks of the steering map inverse lookup block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "steer_map_inverse_lookup_assert.svh"

module smil_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_ready,
  input logic [smil_pkg::CMD_W-1:0]      item_cmd,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [smil_pkg::VAL_W-1:0]      command_out
);
  import smil_pkg::*;

  // A query beat occupies the block for the following cycle at least.
  `SMIL_ASSERT_RUN(a_query_busy, item_valid && item_ready && item_cmd == CMD_QUERY |=> !item_ready, "block ready right after a query beat")

  // A write beat leaves the block ready for the next beat.
  `SMIL_ASSERT_RUN(a_write_ready, item_valid && item_ready && item_cmd != CMD_QUERY |=> item_ready, "block not ready after a write beat")

  // A stalled result beat keeps its command.
  `SMIL_ASSERT_RUN(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(command_out), "stalled result changed")

  // Reset clears any pending result.
  `SMIL_ASSERT_ALL(a_reset_empty, rst |=> !result_valid, "result valid after reset")

endmodule

bind steer_map_inverse_lookup smil_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_cmd     (item.cmd),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .command_out  (result.command_out)
);

`default_nettype wire
